@@ rtl/ballistic_pitch_solver_defines.svh @@
// Assertion macros shared by the ballistic pitch solver RTL.
// Depends on nothing; users must have clk and rst in scope.
`ifndef BALLISTIC_PITCH_SOLVER_DEFINES_SVH
`define BALLISTIC_PITCH_SOLVER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BPS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ballistic_pitch_solver: check failed");

// Next-cycle implication, disabled while in reset.
`define BPS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ballistic_pitch_solver: check failed");

`endif

@@ rtl/bps_pkg.sv @@
// Constants and tables shared by the ballistic pitch solver modules.
// Depends on nothing.
package bps_pkg;

  localparam logic [15:0] GRAVITY_RESET = 16'd40072;

  localparam int SQ1_W = 74;   // discriminant radicand width
  localparam int SQ2_W = 108;  // magnitude radicand width, scaled by 2^32
  localparam int NA_W = 37;    // magnitude of the numerator
  localparam int QW_W = 32;    // G*D and G*V
  localparam int R_W = SQ2_W / 2;
  localparam int TIME_W = 24;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int ANGLE_MAX = 25736;

  localparam int CORDIC_STEPS = 25;
  localparam int CORDIC_LAT = CORDIC_STEPS + 3;
  localparam int DIV_LAT = TIME_W + 2;

  // atan(2^-i) in units of 2^-24 rad.
  localparam logic [23:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117, 24'd262123, 24'd131069, 24'd65536, 24'd32768,
    24'd16384, 24'd8192, 24'd4096, 24'd2048, 24'd1024,
    24'd512, 24'd256, 24'd128, 24'd64, 24'd32,
    24'd16, 24'd8, 24'd4, 24'd2, 24'd1
  };

endpackage

@@ rtl/bps_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, with a side channel.
// Depends on nothing.
module bps_sqrt #(
  parameter int IN_W = 74,
  parameter int SIDE_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [SIDE_W-1:0]   out_side
);
  localparam int RW = IN_W / 2;

  logic              valid [0:RW];
  logic [IN_W-1:0]   rad   [0:RW];
  logic [RW+1:0]     rem   [0:RW];
  logic [RW-1:0]     acc   [0:RW];
  logic [SIDE_W-1:0] side  [0:RW];

  assign valid[0] = in_valid;
  assign rad[0]   = radicand;
  assign rem[0]   = '0;
  assign acc[0]   = '0;
  assign side[0]  = in_side;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          fits;

    always_comb begin
      rem_sh = {rem[s][RW:0], rad[s][IN_W-1 -: 2]};
      trial  = {1'b0, acc[s], 2'b01};
      fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else begin
        valid[s+1] <= valid[s];
      end
      rad[s+1]  <= {rad[s][IN_W-3:0], 2'b00};
      rem[s+1]  <= fits ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
      acc[s+1]  <= {acc[s][RW-2:0], fits};
      side[s+1] <= side[s];
    end
  end

  assign out_valid = valid[RW];
  assign root      = acc[RW];
  assign out_side  = side[RW];

endmodule

@@ rtl/bps_divider.sv @@
// Pipelined restoring divider for the flight time: saturation test,
// one quotient bit per stage, then round half up. Depends on bps_pkg.
module bps_divider
  import bps_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [R_W-1:0]    dividend,
  input  logic [QW_W-1:0]   divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [TIME_W-1:0] quotient,
  output logic [SIDE_W-1:0] out_side
);
  logic              valid [0:TIME_W];
  logic              sat   [0:TIME_W];
  logic [QW_W-1:0]   rem   [0:TIME_W];
  logic [TIME_W-1:0] low   [0:TIME_W];
  logic [TIME_W-1:0] quo   [0:TIME_W];
  logic [QW_W-1:0]   dsr   [0:TIME_W];
  logic [SIDE_W-1:0] side  [0:TIME_W];

  // Entry stage: a quotient of 2^24 or more saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
    end
    sat[0]  <= QW_W'(dividend[R_W-1:TIME_W]) >= divisor;
    rem[0]  <= QW_W'(dividend[R_W-1:TIME_W]);
    low[0]  <= dividend[TIME_W-1:0];
    quo[0]  <= '0;
    dsr[0]  <= divisor;
    side[0] <= in_side;
  end

  for (genvar k = 0; k < TIME_W; k++) begin : g_step
    logic [QW_W:0] rem_sh;
    logic          fits;

    always_comb begin
      rem_sh = {rem[k], low[k][TIME_W-1]};
      fits   = rem_sh >= {1'b0, dsr[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else begin
        valid[k+1] <= valid[k];
      end
      sat[k+1]  <= sat[k];
      rem[k+1]  <= fits ? QW_W'(rem_sh - {1'b0, dsr[k]}) : rem_sh[QW_W-1:0];
      low[k+1]  <= {low[k][TIME_W-2:0], 1'b0};
      quo[k+1]  <= {quo[k][TIME_W-2:0], fits};
      dsr[k+1]  <= dsr[k];
      side[k+1] <= side[k];
    end
  end

  logic            round_up;
  logic [TIME_W:0] rounded;

  always_comb begin
    round_up = {rem[TIME_W], 1'b0} >= {1'b0, dsr[TIME_W]};
    rounded  = (TIME_W+1)'(quo[TIME_W]) + (TIME_W+1)'(round_up);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid[TIME_W];
    end
    quotient <= (sat[TIME_W] || rounded[TIME_W]) ? TIME_MAX : rounded[TIME_W-1:0];
    out_side <= side[TIME_W];
  end

endmodule

@@ rtl/bps_cordic.sv @@
// Pipelined vectoring CORDIC giving the signed Q2.14 pitch angle.
// Normalizes the operands, runs one rotation per stage. Depends on bps_pkg.
module bps_cordic
  import bps_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [QW_W-1:0]    x,
  input  logic [NA_W-1:0]    y,
  input  logic               neg,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  output logic signed [15:0] angle,
  output logic [SIDE_W-1:0]  out_side
);
  localparam int CW = 34;
  localparam int ZW = 27;
  localparam logic [5:0] NORM_POS = 6'd29;

  function automatic logic [5:0] lead_one(input logic [NA_W-1:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < NA_W; i++) begin
      if (m[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // Leading-one stage.
  logic              a_valid;
  logic [NA_W-1:0]   a_x;
  logic [NA_W-1:0]   a_y;
  logic [5:0]        a_pos;
  logic              a_neg;
  logic [SIDE_W-1:0] a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_x    <= NA_W'(x);
    a_y    <= y;
    a_pos  <= lead_one(NA_W'(x) | y);
    a_neg  <= neg;
    a_side <= in_side;
  end

  // Shift stage: largest operand into [2^29, 2^30).
  logic [NA_W-1:0] sh_x;
  logic [NA_W-1:0] sh_y;

  always_comb begin
    if (a_pos > NORM_POS) begin
      sh_x = a_x >> (a_pos - NORM_POS);
      sh_y = a_y >> (a_pos - NORM_POS);
    end else begin
      sh_x = a_x << (NORM_POS - a_pos);
      sh_y = a_y << (NORM_POS - a_pos);
    end
  end

  logic                 valid [0:CORDIC_STEPS];
  logic signed [CW-1:0] cx    [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z     [0:CORDIC_STEPS];
  logic                 sgn   [0:CORDIC_STEPS];
  logic [SIDE_W-1:0]    side  [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= a_valid;
    end
    cx[0]   <= CW'(sh_x[29:0]);
    cy[0]   <= CW'(sh_y[29:0]);
    z[0]    <= '0;
    sgn[0]  <= a_neg;
    side[0] <= a_side;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] da;

    always_comb begin
      dx = cx[i] >>> i;
      dy = cy[i] >>> i;
      da = ZW'(ATAN_TAB[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      if (cy[i] > 0) begin
        cx[i+1] <= cx[i] + dy;
        cy[i+1] <= cy[i] - dx;
        z[i+1]  <= z[i] + da;
      end else begin
        cx[i+1] <= cx[i] - dy;
        cy[i+1] <= cy[i] + dx;
        z[i+1]  <= z[i] - da;
      end
      sgn[i+1]  <= sgn[i];
      side[i+1] <= side[i];
    end
  end

  // Clamp at zero, round half up from 2^-24 to 2^-14, apply the sign.
  logic [ZW-1:0] z_pos;
  logic [ZW-1:0] z_rnd;
  logic [15:0]   mag;

  always_comb begin
    z_pos = z[CORDIC_STEPS][ZW-1] ? '0 : z[CORDIC_STEPS];
    z_rnd = z_pos + ZW'(512);
    mag   = z_rnd[25:10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid[CORDIC_STEPS];
    end
    angle    <= sgn[CORDIC_STEPS] ? -signed'(mag) : signed'(mag);
    out_side <= side[CORDIC_STEPS];
  end

endmodule

@@ rtl/ballistic_pitch_solver.sv @@
// Top level of the drag-free ballistic pitch solver: front-end products,
// discriminant root, numerator, magnitude root, divider and CORDIC.
// Depends on bps_pkg, bps_sqrt, bps_divider, bps_cordic and the defines header.
//
//  Channel   Ports                                              Handshake
//  --------  -------------------------------------------------  ----------------
//  request   muzzle_speed, horizontal_distance, height_diff.    start / busy
//  result    no_solution, launch_angle, flight_time             done (1 cycle)
//  config    gravity_wdata                                      gravity_we
//
// A request is taken at any clock edge with start high and busy low; busy is
// high only during reset, so one request can enter every cycle. Each request
// yields exactly one result, marked by done; the delay after the accepting edge
// includes the two bit-serial square root pipelines (37 and 54 stages), the
// 26-stage divider and the 28-stage CORDIC.
// The receiver cannot stall the results, so nothing in the pipeline ever waits.
// Synchronous reset clears every valid bit and loads the default gravity.
`include "ballistic_pitch_solver_defines.svh"

module ballistic_pitch_solver
  import bps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        muzzle_speed,
  input  logic [15:0]        horizontal_distance,
  input  logic signed [15:0] height_difference,
  input  logic               gravity_we,
  input  logic [15:0]        gravity_wdata,
  output logic               done,
  output logic               no_solution,
  output logic signed [15:0] launch_angle,
  output logic [TIME_W-1:0]  flight_time
);
  localparam int LATENCY = 4 + SQ1_W / 2 + 1 + 3 + SQ2_W / 2 + DIV_LAT + CORDIC_LAT + 1;

  // Fields carried alongside the discriminant.
  typedef struct packed {
    logic        nos;
    logic        gz;
    logic [15:0] v;
    logic [15:0] d;
    logic [15:0] h;
    logic [31:0] v2;
    logic [31:0] gd;
    logic [31:0] gv;
  } front_t;

  // Fields carried alongside the magnitude root.
  typedef struct packed {
    logic [NA_W-1:0] na;
    logic [QW_W-1:0] q;
    logic [QW_W-1:0] w;
    logic            neg;
    logic            nos;
  } mag_side_t;

  typedef struct packed {
    logic [NA_W-1:0] na;
    logic [QW_W-1:0] q;
    logic            neg;
    logic            nos;
  } div_side_t;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic              nos;
  } cor_side_t;

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // Gravity register; write only while the pipeline is empty (not enforced).
  logic [15:0] gravity;
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= GRAVITY_RESET;
    end else if (gravity_we) begin
      gravity <= gravity_wdata;
    end
  end

  // Stage 1: first-level products. |H| fits 16 bits unsigned even for -32768.
  logic [15:0] habs;
  assign habs = height_difference[15] ? 16'(~height_difference + 16'sd1)
                                      : height_difference;

  logic        f1_valid;
  front_t      f1;
  logic [31:0] f1_gh;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    f1.nos <= (muzzle_speed == '0) || (horizontal_distance == '0);
    f1.gz  <= (gravity == '0);
    f1.v   <= muzzle_speed;
    f1.d   <= horizontal_distance;
    f1.h   <= height_difference;
    f1.v2  <= 32'(muzzle_speed) * 32'(muzzle_speed);
    f1.gd  <= 32'(gravity) * 32'(horizontal_distance);
    f1.gv  <= 32'(gravity) * 32'(muzzle_speed);
    f1_gh  <= 32'(gravity) * 32'(habs);
  end

  // Stage 2: V^4, (G*D)^2 and G*|H|*V^2.
  logic        f2_valid;
  front_t      f2;
  logic [63:0] f2_v4;
  logic [63:0] f2_gd2;
  logic [63:0] f2_ghv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
    f2     <= f1;
    f2_v4  <= 64'(f1.v2) * 64'(f1.v2);
    f2_gd2 <= 64'(f1.gd) * 64'(f1.gd);
    f2_ghv <= 64'(f1_gh) * 64'(f1.v2);
  end

  // Stage 3: the height term joins whichever side keeps it positive.
  logic            f3_valid;
  front_t          f3;
  logic [SQ1_W-1:0] f3_pos;
  logic [SQ1_W-1:0] f3_neg;
  logic [68:0]     term;
  assign term = {f2_ghv, 5'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else begin
      f3_valid <= f2_valid;
    end
    f3     <= f2;
    f3_pos <= SQ1_W'({f2_v4, 8'b0}) + (f2.h[15] ? SQ1_W'(term) : '0);
    f3_neg <= SQ1_W'(f2_gd2) + (f2.h[15] ? '0 : SQ1_W'(term));
  end

  // Stage 4: discriminant and its sign. Out of reach only matters with gravity.
  logic             f4_valid;
  front_t           f4;
  front_t           f3_upd;
  logic [SQ1_W-1:0] f4_rad;
  logic [SQ1_W:0]   disc;
  assign disc = {1'b0, f3_pos} - {1'b0, f3_neg};

  always_comb begin
    f3_upd     = f3;
    f3_upd.nos = f3.nos || (!f3.gz && disc[SQ1_W]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_valid <= 1'b0;
    end else begin
      f4_valid <= f3_valid;
    end
    f4     <= f3_upd;
    f4_rad <= disc[SQ1_W] ? '0 : disc[SQ1_W-1:0];
  end

  // Discriminant root.
  logic                     s1_valid;
  logic [SQ1_W/2-1:0]       s1_root;
  logic [$bits(front_t)-1:0] s1_side;
  front_t                   s1;

  bps_sqrt #(
    .IN_W  (SQ1_W),
    .SIDE_W($bits(front_t))
  ) u_sqrt_disc (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f4_valid),
    .radicand (f4_rad),
    .in_side  (f4),
    .out_valid(s1_valid),
    .root     (s1_root),
    .out_side (s1_side)
  );
  assign s1 = s1_side;

  // Numerator of the smaller root, or straight-line aim with zero gravity.
  logic signed [NA_W:0] n_full;
  logic [NA_W:0]        n_abs;

  always_comb begin
    if (s1.gz) begin
      n_full = {{(NA_W - 15){s1.h[15]}}, s1.h};
    end else begin
      n_full = {2'b0, s1.v2, 4'b0} - {1'b0, s1_root};
    end
    n_abs = n_full[NA_W] ? (~n_full + 1'b1) : n_full;
  end

  logic      n_valid;
  mag_side_t n_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else begin
      n_valid <= s1_valid;
    end
    n_s.na  <= n_abs[NA_W-1:0];
    n_s.q   <= s1.gz ? QW_W'(s1.d) : s1.gd;
    n_s.w   <= s1.gz ? QW_W'(s1.v) : s1.gv;
    n_s.neg <= n_full[NA_W];
    n_s.nos <= s1.nos;
  end

  // Magnitude N^2 + Q^2, with N^2 split into partial products.
  logic        m1_valid;
  mag_side_t   m1_s;
  logic [63:0] m1_lo2;
  logic [36:0] m1_hilo;
  logic [9:0]  m1_hi2;
  logic [63:0] m1_q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else begin
      m1_valid <= n_valid;
    end
    m1_s    <= n_s;
    m1_lo2  <= 64'(n_s.na[31:0]) * 64'(n_s.na[31:0]);
    m1_hilo <= 37'(n_s.na[36:32]) * 37'(n_s.na[31:0]);
    m1_hi2  <= 10'(n_s.na[36:32]) * 10'(n_s.na[36:32]);
    m1_q2   <= 64'(n_s.q) * 64'(n_s.q);
  end

  logic        m2_valid;
  mag_side_t   m2_s;
  logic [73:0] m2_nsq;
  logic [63:0] m2_q2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else begin
      m2_valid <= m1_valid;
    end
    m2_s   <= m1_s;
    m2_nsq <= {m1_hi2, m1_lo2} + 74'({m1_hilo, 33'b0});
    m2_q2  <= m1_q2;
  end

  logic        m3_valid;
  mag_side_t   m3_s;
  logic [74:0] m3_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_valid <= 1'b0;
    end else begin
      m3_valid <= m2_valid;
    end
    m3_s   <= m2_s;
    m3_mag <= 75'(m2_nsq) + 75'(m2_q2);
  end

  // Root of the magnitude scaled by 2^32.
  logic                         s2_valid;
  logic [R_W-1:0]               s2_root;
  logic [$bits(mag_side_t)-1:0] s2_side;
  mag_side_t                    s2;

  bps_sqrt #(
    .IN_W  (SQ2_W),
    .SIDE_W($bits(mag_side_t))
  ) u_sqrt_mag (
    .clk      (clk),
    .rst      (rst),
    .in_valid (m3_valid),
    .radicand ({1'b0, m3_mag, 32'b0}),
    .in_side  (m3_s),
    .out_valid(s2_valid),
    .root     (s2_root),
    .out_side (s2_side)
  );
  assign s2 = s2_side;

  div_side_t s2_div;
  assign s2_div = '{na: s2.na, q: s2.q, neg: s2.neg, nos: s2.nos};

  // Flight time: root / (G*V), rounded and saturated.
  logic                         dv_valid;
  logic [TIME_W-1:0]            dv_time;
  logic [$bits(div_side_t)-1:0] dv_side;
  div_side_t                    dv;

  bps_divider #(
    .SIDE_W($bits(div_side_t))
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s2_valid),
    .dividend (s2_root),
    .divisor  (s2.w),
    .in_side  (s2_div),
    .out_valid(dv_valid),
    .quotient (dv_time),
    .out_side (dv_side)
  );
  assign dv = dv_side;

  cor_side_t dv_cor;
  assign dv_cor = '{t: dv_time, nos: dv.nos};

  // Pitch angle atan2(N, Q).
  logic                         cr_valid;
  logic signed [15:0]           cr_angle;
  logic [$bits(cor_side_t)-1:0] cr_side;
  cor_side_t                    cr;

  bps_cordic #(
    .SIDE_W($bits(cor_side_t))
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dv_valid),
    .x        (dv.q),
    .y        (dv.na),
    .neg      (dv.neg),
    .in_side  (dv_cor),
    .out_valid(cr_valid),
    .angle    (cr_angle),
    .out_side (cr_side)
  );
  assign cr = cr_side;

  // Result register; an unsolvable request reports zero angle and time.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_valid;
    end
    no_solution  <= cr.nos;
    launch_angle <= cr.nos ? '0 : cr_angle;
    flight_time  <= cr.nos ? '0 : cr.t;
  end

  `BPS_ASSERT_SAME(a_nosol_zero, done && no_solution, launch_angle == '0 && flight_time == '0)
  `BPS_ASSERT_SAME(a_angle_range, done, launch_angle <= 16'(ANGLE_MAX) && launch_angle >= -16'(ANGLE_MAX))
  `BPS_ASSERT_NEXT(a_latency, $past(!accept, LATENCY - 1), !done)

endmodule
